// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the Alamouti combiner, used by acb_obuf.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define ACB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define ACB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ACB_ASSERT(lbl, prop, msg)
`define ACB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/acb_pkg.sv =====
// Shared widths and types of the Alamouti combiner.
// Depends on nothing.
package acb_pkg;
  localparam int SW   = 16;        // sample width
  localparam int PW   = 2 * SW;    // product width
  localparam int SUMW = PW + 2;    // sum of four products
  localparam int MSW  = SW + 1;    // sum of two magnitudes
  localparam int NW   = SUMW;      // doubled absolute numerator

  typedef logic signed [SW-1:0]   samp_t;
  typedef logic signed [SUMW-1:0] acc_t;

  typedef struct packed {
    acc_t r2i;
    acc_t r2r;
    acc_t r1i;
    acc_t r1r;
  } sums_t;

  typedef struct packed {
    logic  zero_channel;
    samp_t sym2_imag;
    samp_t sym2_real;
    samp_t sym1_imag;
    samp_t sym1_real;
  } res_t;
endpackage

// ===== sv/alamouti_2x1_combiner.sv =====
// Top level of the Alamouti 2x1 pair combiner.
// Depends on acb_pkg, acb_sqrt, acb_div and acb_obuf.
//
// One input transfer carries a received pair x1, x2 and the channel
// estimates h1, h2, all Q1.15. One output transfer carries the two decoded
// symbols, scaled by the mean channel magnitude and saturated, plus a flag
// in tuser that marks an all-zero channel (symbols are then zero).
// Throughput is one pair per cycle while the receiver keeps up. The pipeline
// holds one product stage, one sum stage, SW square root stages, one
// magnitude sum stage, SW + 1 divider stages and the output register. The
// square root resolves one bit per stage and the divider one quotient bit
// per step stage, which sets the depth.
// When the receiver stalls, the output register holds its result and one
// more result goes into a skid entry; only then does the pipeline freeze
// and tready fall, so nothing is lost or repeated. Reset empties the
// pipeline and both output entries; no payload is cleared.
module alamouti_2x1_combiner
  import acb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // rx1_real, rx1_imag, rx2_real, rx2_imag, chan1_real, chan1_imag,
  // chan2_real, chan2_imag, 16 bits each from the lowest bit up.
  input  logic [8*SW-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // sym1_real, sym1_imag, sym2_real, sym2_imag from the lowest bit up.
  output logic [4*SW-1:0]  m_axis_tdata,
  // zero_channel.
  output logic             m_axis_tuser
);
  localparam int NST = 2 * SW + 4;

  logic ce;
  logic vld_q [NST];

  samp_t x1r, x1i, x2r, x2i, h1r, h1i, h2r, h2i;
  assign x1r = s_axis_tdata[0*SW +: SW];
  assign x1i = s_axis_tdata[1*SW +: SW];
  assign x2r = s_axis_tdata[2*SW +: SW];
  assign x2i = s_axis_tdata[3*SW +: SW];
  assign h1r = s_axis_tdata[4*SW +: SW];
  assign h1i = s_axis_tdata[5*SW +: SW];
  assign h2r = s_axis_tdata[6*SW +: SW];
  assign h2i = s_axis_tdata[7*SW +: SW];

  assign s_axis_tready = ce;

  // Valid bits travel with the data; an idle input leaves a bubble.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (ce) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Stage 1: all cross products and the channel power terms.
  logic signed [PW-1:0] p_q [16];
  logic [PW-1:0] sq1r_q, sq1i_q, sq2r_q, sq2i_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      p_q[0]  <= x1r * h1r;  p_q[1]  <= x1i * h1i;
      p_q[2]  <= h2r * x2r;  p_q[3]  <= h2i * x2i;
      p_q[4]  <= x1i * h1r;  p_q[5]  <= x1r * h1i;
      p_q[6]  <= h2i * x2r;  p_q[7]  <= h2r * x2i;
      p_q[8]  <= x2r * h1r;  p_q[9]  <= x2i * h1i;
      p_q[10] <= h2r * x1r;  p_q[11] <= h2i * x1i;
      p_q[12] <= x2i * h1r;  p_q[13] <= x2r * h1i;
      p_q[14] <= h2i * x1r;  p_q[15] <= h2r * x1i;
      sq1r_q <= $unsigned(PW'(h1r) * PW'(h1r));
      sq1i_q <= $unsigned(PW'(h1i) * PW'(h1i));
      sq2r_q <= $unsigned(PW'(h2r) * PW'(h2r));
      sq2i_q <= $unsigned(PW'(h2i) * PW'(h2i));
    end
  end

  // Stage 2: combiner sums and the squared channel magnitudes.
  acc_t pe [16];
  for (genvar j = 0; j < 16; j++) begin : g_ext
    assign pe[j] = SUMW'(p_q[j]);
  end
  sums_t sums_q;
  logic [PW-1:0] pw1_q, pw2_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      sums_q.r1r <= pe[0] + pe[1] + pe[2] + pe[3];
      sums_q.r1i <= pe[4] - pe[5] + pe[6] - pe[7];
      sums_q.r2r <= pe[8] + pe[9] - pe[10] - pe[11];
      sums_q.r2i <= pe[12] - pe[13] - pe[14] + pe[15];
      pw1_q <= sq1r_q + sq1i_q;
      pw2_q <= sq2r_q + sq2i_q;
    end
  end

  // Square roots, with the sums delayed alongside.
  logic [SW-1:0] mag1, mag2;
  acb_sqrt u_sqrt1 (.clk_i(clk_i), .ce_i(ce), .sq_i(pw1_q), .mag_o(mag1));
  acb_sqrt u_sqrt2 (.clk_i(clk_i), .ce_i(ce), .sq_i(pw2_q), .mag_o(mag2));

  sums_t sdly_q [SW];
  always_ff @(posedge clk_i) begin
    if (ce) begin
      sdly_q[0] <= sums_q;
      for (int i = 1; i < SW; i++) sdly_q[i] <= sdly_q[i-1];
    end
  end

  // Magnitude sum stage: the numerator becomes twice its absolute value,
  // which makes the divisor the magnitude sum rather than its half.
  acc_t sv [4];
  assign sv[0] = sdly_q[SW-1].r1r;
  assign sv[1] = sdly_q[SW-1].r1i;
  assign sv[2] = sdly_q[SW-1].r2r;
  assign sv[3] = sdly_q[SW-1].r2i;

  logic [MSW-1:0] msum_q;
  logic [NW-1:0]  num_q [4];
  logic           neg_q [4];
  logic           zdly_q [SW+2];
  always_ff @(posedge clk_i) begin
    if (ce) begin
      msum_q    <= MSW'(mag1) + MSW'(mag2);
      zdly_q[0] <= (mag1 == '0) && (mag2 == '0);
      for (int i = 1; i < SW + 2; i++) zdly_q[i] <= zdly_q[i-1];
      for (int c = 0; c < 4; c++) begin
        neg_q[c] <= sv[c][SUMW-1];
        num_q[c] <= (sv[c][SUMW-1] ? NW'(-sv[c]) : NW'(sv[c])) << 1;
      end
    end
  end

  samp_t sym [4];
  for (genvar c = 0; c < 4; c++) begin : g_div
    acb_div u_div (
      .clk_i(clk_i), .ce_i(ce), .num_i(num_q[c]), .neg_i(neg_q[c]),
      .den_i(msum_q), .sym_o(sym[c])
    );
  end

  // The zero flag is aligned with the divider outputs and clears them.
  logic zero_out;
  res_t res;
  assign zero_out = zdly_q[SW+1];
  always_comb begin
    res.zero_channel = zero_out;
    res.sym1_real    = zero_out ? samp_t'(0) : sym[0];
    res.sym1_imag    = zero_out ? samp_t'(0) : sym[1];
    res.sym2_real    = zero_out ? samp_t'(0) : sym[2];
    res.sym2_imag    = zero_out ? samp_t'(0) : sym[3];
  end

  res_t out_res;
  acb_obuf u_obuf (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(vld_q[NST-1]), .in_data_i(res),
    .ce_o(ce), .out_valid_o(m_axis_tvalid), .out_data_o(out_res),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {out_res.sym2_imag, out_res.sym2_real,
                         out_res.sym1_imag, out_res.sym1_real};
  assign m_axis_tuser = out_res.zero_channel;
endmodule

// ===== sv/acb_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on acb_pkg.
module acb_sqrt
  import acb_pkg::*;
(
  input  logic          clk_i,
  input  logic          ce_i,
  input  logic [PW-1:0] sq_i,
  output logic [SW-1:0] mag_o
);
  logic [PW:0] res_q [SW];
  logic [PW:0] v_q   [SW];
  logic [PW:0] res_in [SW];
  logic [PW:0] v_in   [SW];
  logic [PW:0] res_d  [SW];
  logic [PW:0] v_d    [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam int B = PW - 2 - 2 * k;
    logic [PW:0] bitv;
    logic [PW:0] trial;
    if (k == 0) begin : g_first
      assign res_in[k] = '0;
      assign v_in[k]   = {1'b0, sq_i};
    end else begin : g_next
      assign res_in[k] = res_q[k-1];
      assign v_in[k]   = v_q[k-1];
    end
    assign bitv  = (PW+1)'(1) << B;
    assign trial = res_in[k] + bitv;
    always_comb begin
      if (v_in[k] >= trial) begin
        v_d[k]   = v_in[k] - trial;
        res_d[k] = (res_in[k] >> 1) + bitv;
      end else begin
        v_d[k]   = v_in[k];
        res_d[k] = res_in[k] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        res_q[k] <= res_d[k];
        v_q[k]   <= v_d[k];
      end
    end
  end

  assign mag_o = res_q[SW-1][SW-1:0];
endmodule

// ===== sv/acb_div.sv =====
// Pipelined restoring divider with truncation and saturation to a sample.
// Depends on acb_pkg; data passes the flag stage, the quotient bit stages and the output register.
module acb_div
  import acb_pkg::*;
(
  input  logic           clk_i,
  input  logic           ce_i,
  input  logic [NW-1:0]  num_i,
  input  logic           neg_i,
  input  logic [MSW-1:0] den_i,
  output samp_t          sym_o
);
  logic [NW-1:0]  rem_q [SW];
  logic [SW-2:0]  quo_q [SW];
  logic [MSW-1:0] den_q [SW];
  logic           neg_q [SW];
  logic           big_q [SW];
  samp_t          sym_q;

  // First stage flags quotients of a full sample or more.
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0] <= num_i;
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      big_q[0] <= num_i >= (NW'(den_i) << (SW - 1));
    end
  end

  for (genvar k = 1; k < SW; k++) begin : g_step
    localparam int I = SW - 1 - k;
    logic [NW-1:0] dsh;
    logic [NW-1:0] rem_d;
    logic [SW-2:0] quo_d;
    assign dsh = NW'(den_q[k-1]) << I;
    always_comb begin
      rem_d = rem_q[k-1];
      quo_d = quo_q[k-1];
      if (rem_q[k-1] >= dsh) begin
        rem_d = rem_q[k-1] - dsh;
        quo_d[I] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        big_q[k] <= big_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (neg_q[SW-1]) begin
        sym_q <= big_q[SW-1] ? {1'b1, {(SW-1){1'b0}}} : -$signed({1'b0, quo_q[SW-1]});
      end else begin
        sym_q <= big_q[SW-1] ? {1'b0, {(SW-1){1'b1}}} : $signed({1'b0, quo_q[SW-1]});
      end
    end
  end

  assign sym_o = sym_q;
endmodule

// ===== sv/acb_obuf.sv =====
// Output register with one skid entry for the combiner result stream.
// Depends on acb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module acb_obuf
  import acb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  res_t in_data_i,
  output logic ce_o,
  output logic out_valid_o,
  output res_t out_data_o,
  input  logic out_ready_i
);
  logic ov_q, ov_d;
  logic sv_q, sv_d;
  res_t od_q, sd_q;

  assign ce_o = !sv_q;

  always_comb begin
    ov_d = ov_q;
    sv_d = sv_q;
    if (sv_q) begin
      if (out_ready_i) begin
        sv_d = 1'b0;
      end
    end else if (in_valid_i) begin
      if (ov_q && !out_ready_i) begin
        sv_d = 1'b1;
      end else begin
        ov_d = 1'b1;
      end
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (out_ready_i) begin
        od_q <= sd_q;
      end
    end else if (in_valid_i) begin
      if (ov_q && !out_ready_i) begin
        sd_q <= in_data_i;
      end else begin
        od_q <= in_data_i;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  `ACB_ASSERT_ALWAYS(a_skid_needs_out, sv_q |-> ov_q, "skid entry full while output empty")
  `ACB_ASSERT(a_skid_holds, sv_q && !out_ready_i |=> sv_q && $stable(sd_q), "skid entry lost")
  `ACB_ASSERT(a_zero_out, ov_q && od_q.zero_channel |-> od_q.sym1_real == '0 && od_q.sym1_imag == '0 && od_q.sym2_real == '0 && od_q.sym2_imag == '0, "zero channel with nonzero symbols")
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the Alamouti 2x1 pair combiner.
// Depends on acb_pkg and the alamouti_2x1_combiner RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import acb_pkg::*;

  localparam int LATENCY   = 2 * SW + 5;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    samp_t h2i;
    samp_t h2r;
    samp_t h1i;
    samp_t h1r;
    samp_t x2i;
    samp_t x2r;
    samp_t x1i;
    samp_t x1r;
  } pair_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [8*SW-1:0] s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [4*SW-1:0] m_axis_tdata;
  logic            m_axis_tuser;

  pair_t pending_pairs[$];
  res_t  expected_symbols[$];
  int    mismatch_count;
  int    idle_cycles;
  bit    stim_done;
  bit    hold_off;

  alamouti_2x1_combiner uut (.*);

  // 12 ns clock: low half, then high half.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Gap length: mostly zero or short, sometimes long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Truncated 2*num/den, saturated to the sample range.
  function automatic samp_t scale_sat(logic signed [63:0] num, logic signed [63:0] den);
    logic signed [63:0] q;
    q = (2 * num) / den;
    if (q > 32767) return 16'sh7fff;
    if (q < -32768) return 16'sh8000;
    return samp_t'(q);
  endfunction

  function automatic res_t combine_pair(pair_t p);
    logic signed [63:0] x1r, x1i, x2r, x2i, h1r, h1i, h2r, h2i, msum;
    res_t r;
    x1r = p.x1r; x1i = p.x1i; x2r = p.x2r; x2i = p.x2i;
    h1r = p.h1r; h1i = p.h1i; h2r = p.h2r; h2i = p.h2i;
    msum = isqrt(h1r * h1r + h1i * h1i) + isqrt(h2r * h2r + h2i * h2i);
    r = '0;
    if (msum == 0) begin
      r.zero_channel = 1'b1;
      return r;
    end
    r.sym1_real = scale_sat(x1r * h1r + x1i * h1i + h2r * x2r + h2i * x2i, msum);
    r.sym1_imag = scale_sat(x1i * h1r - x1r * h1i + h2i * x2r - h2r * x2i, msum);
    r.sym2_real = scale_sat(x2r * h1r + x2i * h1i - h2r * x1r - h2i * x1i, msum);
    r.sym2_imag = scale_sat(x2i * h1r - x2r * h1i - h2i * x1r + h2r * x1i, msum);
    return r;
  endfunction

  function automatic samp_t rand_samp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    if (r == 2) return samp_t'($urandom_range(0, 15)) - 16'sd8;
    if (r == 3) return samp_t'($urandom_range(0, 255)) - 16'sd128;
    return samp_t'($urandom);
  endfunction

  // Stimulus: directed corners, then random pairs.
  initial begin
    pair_t p;
    samp_t ext[4];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001};
    p = '0;
    pending_pairs.push_back(p);                     // everything zero
    p = {8{16'sh8000}};
    pending_pairs.push_back(p);                     // all most negative
    p = {8{16'sh7fff}};
    pending_pairs.push_back(p);                     // all most positive
    p = {16'sh0, 16'sh0, 16'sh0, 16'sh0, {4{16'sh7fff}}};
    pending_pairs.push_back(p);                     // zero channel, full data
    p = {16'sh0, 16'sh0, 16'sh0, 16'sh0, {4{16'sh8000}}};
    pending_pairs.push_back(p);
    p = {16'sh0, 16'sh0, 16'sh0, 16'sh1, {4{16'sh7fff}}};
    pending_pairs.push_back(p);                     // tiny channel, saturation
    p = {16'sh0, 16'sh0, 16'sh0, 16'sh1, {4{16'sh8000}}};
    pending_pairs.push_back(p);
    p = {16'sh0, 16'sh1, 16'sh0, 16'sh0, 16'sh0001, 16'sh8000, 16'sh7fff, 16'sh8000};
    pending_pairs.push_back(p);
    for (int i = 0; i < 16; i++) begin
      p = {ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
           ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
           ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
           ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)]};
      pending_pairs.push_back(p);
    end
    for (int i = 0; i < 400; i++) begin
      p = {rand_samp(), rand_samp(), rand_samp(), rand_samp(),
           rand_samp(), rand_samp(), rand_samp(), rand_samp()};
      if ($urandom_range(0, 19) == 0) begin
        p.h1r = 0; p.h1i = 0; p.h2r = 0; p.h2i = 0;
      end
      pending_pairs.push_back(p);
    end
    stim_done = 1'b1;
  end

  // Driver: presents the next pending pair after a random gap.
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else begin
      // An accepted pair leaves the queue here, so the head is always the
      // next pair to offer.
      if (s_axis_tvalid && s_axis_tready) begin
        expected_symbols.push_back(combine_pair(pair_t'(s_axis_tdata)));
        void'(pending_pairs.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // keep offering the same transfer
      end else if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else begin
        if (pending_pairs.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_pairs[0];
          send_gap      <= gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus one long hold-off while the
  // sender keeps going, so the pipeline fills and input stalls.
  int stall_cnt;
  int accepted_in;
  int hold_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= 0;
      accepted_in   <= 0;
      hold_cnt      <= 0;
      hold_off      <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) accepted_in <= accepted_in + 1;
      if (!hold_off && hold_cnt == 0 && accepted_in == 60) begin
        hold_off <= 1'b1;
        hold_cnt <= 200;
        m_axis_tready <= 1'b0;
      end else if (hold_off) begin
        if (hold_cnt == 1) hold_off <= 1'b0;
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= (hold_cnt == 1);
      end else if (stall_cnt > 0) begin
        stall_cnt     <= stall_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_cnt <= gap_len();
      end
    end
  end

  // Monitor: compares each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_t got, want;
      got = res_t'({m_axis_tuser, m_axis_tdata});
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected output transfer %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_symbols.pop_front();
        if (got.sym1_real !== want.sym1_real)
          $display("%0t: sym1_real expected %0d got %0d", $time, want.sym1_real,
                   got.sym1_real);
        if (got.sym1_imag !== want.sym1_imag)
          $display("%0t: sym1_imag expected %0d got %0d", $time, want.sym1_imag,
                   got.sym1_imag);
        if (got.sym2_real !== want.sym2_real)
          $display("%0t: sym2_real expected %0d got %0d", $time, want.sym2_real,
                   got.sym2_real);
        if (got.sym2_imag !== want.sym2_imag)
          $display("%0t: sym2_imag expected %0d got %0d", $time, want.sym2_imag,
                   got.sym2_imag);
        if (got.zero_channel !== want.zero_channel)
          $display("%0t: zero_channel expected %0b got %0b", $time,
                   want.zero_channel, got.zero_channel);
        if (got !== want) mismatch_count++;
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("alamouti_2x1_combiner test failed");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    rst_ni         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_pairs.size() == 0 && !s_axis_tvalid);
    wait (expected_symbols.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_symbols.size() == 0)
      $display("alamouti_2x1_combiner test passed");
    else
      $display("alamouti_2x1_combiner test failed");
    $finish;
  end
endmodule

// ===== alamouti_2x1_combiner.f =====
+incdir+sv
sv/acb_pkg.sv
sv/acb_sqrt.sv
sv/acb_div.sv
sv/acb_obuf.sv
sv/alamouti_2x1_combiner.sv
dv/testbench.sv
